// ===== design/mrrc_pkg.sv =====
`timescale 1ns / 1ps

package mrrc_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // Frame verdicts.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_WRONG_ADDR = 3'd1;
  localparam logic [2:0] ST_EXCEPTION  = 3'd2;
  localparam logic [2:0] ST_WRONG_FUNC = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;
  localparam logic [2:0] ST_CRC_BAD    = 3'd5;
  localparam logic [2:0] ST_TIMEOUT    = 3'd6;

  // Header faults noted before the byte count arrives.
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ADDR = 2'd1;
  localparam logic [1:0] FAULT_EXC  = 2'd2;
  localparam logic [1:0] FAULT_FUNC = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [7:0]  COUNT_LIMIT = 8'hFF;

  // One result word.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] payload_length;
  } res_t;

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/modbus_rtu_response_checker.sv =====
// Each result word is registered, in the skid register first if the output stalls.
// One word per cycle while in_stall is low; every input word gives exactly one result word.
// A two-entry output stage (result register plus skid register) keeps input and output apart.
// in_stall is high only while the skid register holds a word.
// Reset (synchronous, rst_n low) empties the output stage, idles the checker and
// loads the registers with address 1, function 3 and payload limit 255.
`timescale 1ns / 1ps

module modbus_rtu_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_done,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic [7:0]  out_payload_length,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import mrrc_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC_LO = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;

  // Configuration registers.
  logic [7:0] exp_addr_r;
  logic [6:0] exp_func_r;
  logic [7:0] max_len_r;

  // Frame state.
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [8:0]  seen_r, seen_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [1:0]  fault_r, fault_nxt;

  // Output stage.
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res;

  logic        in_take, out_free, cfg_wr;
  logic [15:0] crc_upd;
  logic [7:0]  exc_func;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_stall = skid_valid_r;
  assign in_take  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_ADDRESS:  prdata = {24'd0, exp_addr_r};
      REG_FUNCTION: prdata = {25'd0, exp_func_r};
      REG_MAX_LEN:  prdata = {24'd0, max_len_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign crc_upd  = crc_byte(crc_r, in_rx_byte);
  assign exc_func = {1'b0, exp_func_r} | EXC_FLAG;

  // Per-word frame checking.
  always_comb begin
    logic finish;
    finish     = 1'b0;
    res        = '0;
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    count_nxt  = count_r;
    seen_nxt   = seen_r;
    crc_lo_nxt = crc_lo_r;
    fault_nxt  = fault_r;

    if (in_kind == KIND_START) begin
      phase_nxt  = PH_HEADER;
      crc_nxt    = CRC_INIT;
      count_nxt  = 8'd0;
      seen_nxt   = 9'd0;
      crc_lo_nxt = 8'd0;
      fault_nxt  = FAULT_NONE;
    end else if (in_kind == KIND_UNUSED || phase_r == PH_IDLE) begin
      // Nothing happens.
    end else if (in_kind == KIND_TIMEOUT) begin
      finish     = 1'b1;
      res.status = ST_TIMEOUT;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          crc_nxt  = crc_upd;
          seen_nxt = seen_r + 9'd1;
          if (seen_r == 9'd0) begin
            if (in_rx_byte != exp_addr_r) fault_nxt = FAULT_ADDR;
          end else if (seen_r == 9'd1) begin
            if (fault_r == FAULT_NONE) begin
              if (in_rx_byte == exc_func) begin
                fault_nxt = FAULT_EXC;
              end else if (in_rx_byte != {1'b0, exp_func_r}) begin
                fault_nxt = FAULT_FUNC;
              end
            end
          end else begin
            // Third header byte: byte count or exception code.
            if (fault_r == FAULT_EXC) begin
              finish             = 1'b1;
              res.status         = ST_EXCEPTION;
              res.exception_code = in_rx_byte;
            end else if (fault_r == FAULT_ADDR) begin
              finish     = 1'b1;
              res.status = ST_WRONG_ADDR;
            end else if (fault_r == FAULT_FUNC) begin
              finish     = 1'b1;
              res.status = ST_WRONG_FUNC;
            end else if (in_rx_byte > max_len_r || in_rx_byte == COUNT_LIMIT) begin
              finish     = 1'b1;
              res.status = ST_TOO_LONG;
            end else begin
              count_nxt = in_rx_byte;
              phase_nxt = (in_rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          crc_nxt           = crc_upd;
          seen_nxt          = seen_r + 9'd1;
          res.payload_valid = 1'b1;
          res.payload_byte  = in_rx_byte;
          if (seen_nxt >= 9'd3 + {1'b0, count_r}) phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo_nxt = in_rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          finish = 1'b1;
          if ({in_rx_byte, crc_lo_r} == crc_r) begin
            res.status         = ST_OK;
            res.payload_length = count_r;
          end else begin
            res.status = ST_CRC_BAD;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // A verdict closes the frame and clears the frame state.
    if (finish) begin
      res.frame_done = 1'b1;
      phase_nxt      = PH_IDLE;
      crc_nxt        = CRC_INIT;
      count_nxt      = 8'd0;
      seen_nxt       = 9'd0;
      crc_lo_nxt     = 8'd0;
      fault_nxt      = FAULT_NONE;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= 8'd1;
      exp_func_r <= 7'd3;
      max_len_r  <= 8'd255;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ADDRESS:  exp_addr_r <= pwdata[7:0];
        REG_FUNCTION: exp_func_r <= pwdata[6:0];
        REG_MAX_LEN:  max_len_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      crc_r    <= CRC_INIT;
      count_r  <= 8'd0;
      seen_r   <= 9'd0;
      crc_lo_r <= 8'd0;
      fault_r  <= FAULT_NONE;
    end else if (in_take) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      count_r  <= count_nxt;
      seen_r   <= seen_nxt;
      crc_lo_r <= crc_lo_nxt;
      fault_r  <= fault_nxt;
    end
  end

  // Output stage: a word goes to the result register when it is free, else to the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (out_free) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = out_r.payload_valid;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_frame_done     = out_r.frame_done;
  assign out_status         = out_r.status;
  assign out_exception_code = out_r.exception_code;
  assign out_payload_length = out_r.payload_length;

`ifndef SYNTH
  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while the result register is empty");

  // An idle checker carries fresh frame state.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (crc_r == CRC_INIT && seen_r == 9'd0 && count_r == 8'd0))
    else $error("idle checker holds stale frame state");

  // Data phase stays within the declared byte count.
  a_data_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (seen_r >= 9'd3 && seen_r < 9'd3 + {1'b0, count_r}))
    else $error("data byte counter outside the declared count");

  // A verdict word never carries a data byte.
  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> !out_payload_valid)
    else $error("verdict word also carries a data byte");

  // Only an ok verdict reports a length.
  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_payload_length == 8'd0))
    else $error("length reported with a failing verdict");
`endif

endmodule
